// ----- hw/rtl/mdlpm_pkg.sv -----
`timescale 1ns / 1ps

package mdlpm_pkg;

    // Table sizing and load limits.
    localparam int TABLE_DEPTH   = 128;
    localparam int DAY_RECORDS   = 128;
    localparam int MONTH_RECORDS = 36;

    // Load limits are clamped to the table depth and to what an 8-bit position can report.
    localparam int DAY_LIMIT_T   = (DAY_RECORDS < TABLE_DEPTH) ? DAY_RECORDS : TABLE_DEPTH;
    localparam int DAY_LIMIT     = (DAY_LIMIT_T < 255) ? DAY_LIMIT_T : 255;
    localparam int MONTH_LIMIT_T = (MONTH_RECORDS < TABLE_DEPTH) ? MONTH_RECORDS : TABLE_DEPTH;
    localparam int MONTH_LIMIT   = (MONTH_LIMIT_T < 255) ? MONTH_LIMIT_T : 255;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int FLD_W  = 8;
    localparam int POS_W  = 8;
    localparam int DATE_W = 3 * FLD_W;

    // Operation codes carried in tuser.
    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Characters of the reply, after masking to 7 bits.
    localparam logic [6:0] CH_MASK  = 7'h7F;
    localparam logic [6:0] CH_CR    = 7'h0D;
    localparam logic [6:0] CH_OPEN  = 7'h28;
    localparam logic [6:0] CH_CLOSE = 7'h29;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;

    typedef struct packed {
        logic [FLD_W-1:0] day;
        logic [FLD_W-1:0] month;
        logic [FLD_W-1:0] year;
    } date_t;

    // Table write request from the parser.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        date_t             data;
    } wr_req_t;

    typedef enum logic [1:0] {
        PH_OUT,
        PH_DAY,
        PH_MONTH,
        PH_YEAR
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

// ----- hw/rtl/meter_date_list_parse_and_match.sv -----
`timescale 1ns / 1ps

// Date-list parser and date matcher for a meter reply.
// Input beats arrive on the s_axis group: tuser carries the operation (begin, reply
// byte, lookup) and tdata carries the reply byte and the query date. Begin and byte
// beats produce no output beat. A lookup beat produces one output beat on m_axis
// carrying the 1-based position of the first matching stored date, or 0 when none
// matches. A lookup walks the stored table through one compare unit fed by the
// table RAM's registered read port, one entry per cycle. The block accepts no new
// beat from a lookup's acceptance until its result beat is taken, so a stall on
// m_axis_tready simply holds the result and keeps s_axis_tready low.
// month_mode is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
// Reset clears the record count, the parser state and month_mode; the table needs
// no clearing since only entries below the record count are ever read.
module meter_date_list_parse_and_match (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,   // month_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // reply_byte, query_day, query_month, query_year
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // match_position
);

    import mdlpm_pkg::*;

    state_t           state_reg, state_next;
    logic             mode_reg;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pend_reg, pend_next;
    logic [CNT_W-1:0] pend_idx_reg, pend_idx_next;
    date_t            query_reg, query_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic             in_fire;
    logic             out_fire;
    logic             begin_load;
    logic             byte_valid;
    logic             lookup_start;
    logic             rd_issue;
    logic             hit;
    logic             scan_done;
    wr_req_t          wr;
    logic [CNT_W-1:0] record_count;
    date_t            rd_data;

    assign in_fire      = s_axis_tvalid && s_axis_tready;
    assign out_fire     = m_axis_tvalid && m_axis_tready;
    assign begin_load   = in_fire && (s_axis_tuser == OP_BEGIN);
    assign byte_valid   = in_fire && (s_axis_tuser == OP_BYTE);
    assign lookup_start = in_fire && (s_axis_tuser == OP_LOOKUP);

    mdlpm_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .begin_load   (begin_load),
        .byte_valid   (byte_valid),
        .byte_in      (s_axis_tdata[7:0]),
        .month_mode   (mode_reg),
        .wr           (wr),
        .record_count (record_count)
    );

    mdlpm_ram #(
        .WIDTH (DATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_issue),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Shared compare unit: checks the entry read in the previous cycle.
    assign rd_issue  = (state_reg == ST_SCAN) && (rd_idx_reg < record_count);
    assign hit       = (state_reg == ST_SCAN) && pend_reg
                     && (rd_data.month == query_reg.month)
                     && (rd_data.year == query_reg.year)
                     && (mode_reg || (rd_data.day == query_reg.day));
    assign scan_done = (state_reg == ST_SCAN) && !pend_reg && !rd_issue;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (lookup_start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit || scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (state_reg)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_RESULT: m_axis_tvalid = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    assign m_axis_tdata = pos_reg;

    // Scan pointer, pending compare and result.
    always_comb
    begin
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        query_next    = query_reg;
        pos_next      = pos_reg;

        if (lookup_start)
        begin
            rd_idx_next      = '0;
            pend_next        = 1'b0;
            query_next.day   = s_axis_tdata[15:8];
            query_next.month = s_axis_tdata[23:16];
            query_next.year  = s_axis_tdata[31:24];
        end
        else if (state_reg == ST_SCAN)
        begin
            pend_next     = rd_issue;
            pend_idx_next = rd_idx_reg;
            if (rd_issue)
            begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            if (hit)
            begin
                pos_next  = POS_W'(pend_idx_reg + CNT_W'(1));
                pend_next = 1'b0;
            end
            else if (scan_done)
            begin
                pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= 1'b0;
            rd_idx_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            pend_reg   <= pend_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        query_reg    <= query_next;
        pos_reg      <= pos_next;
    end

endmodule

// ----- hw/rtl/mdlpm_ram.sv -----
`timescale 1ns / 1ps

module mdlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/mdlpm_parser.sv -----
`timescale 1ns / 1ps

module mdlpm_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  begin_load,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_in,
    input  logic                  month_mode,
    output mdlpm_pkg::wr_req_t    wr,
    output logic [mdlpm_pkg::CNT_W-1:0] record_count
);

    import mdlpm_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             loading_reg, loading_next;
    logic             skip_reg, skip_next;
    phase_t           phase_reg, phase_next;
    logic [FLD_W-1:0] acc_reg, acc_next;
    date_t            rec_reg, rec_next;

    logic [6:0]       ch;
    logic [6:0]       end_ch;
    logic [3:0]       digit_val;
    logic [FLD_W-1:0] acc_mac;
    logic [CNT_W-1:0] limit;

    assign ch        = byte_in[6:0] & CH_MASK;
    assign end_ch    = (phase_reg == PH_YEAR) ? CH_CLOSE : CH_DOT;
    assign digit_val = 4'(ch - CH_ZERO);
    assign limit     = month_mode ? CNT_W'(MONTH_LIMIT) : CNT_W'(DAY_LIMIT);

    // Decimal accumulate: acc * 10 + digit, kept modulo 256.
    assign acc_mac = {acc_reg[FLD_W-4:0], 3'b000} + {acc_reg[FLD_W-2:0], 1'b0}
                   + {{(FLD_W-4){1'b0}}, digit_val};

    assign record_count = count_reg;

    // Byte parser.
    always_comb
    begin
        count_next   = count_reg;
        loading_next = loading_reg;
        skip_next    = skip_reg;
        phase_next   = phase_reg;
        acc_next     = acc_reg;
        rec_next     = rec_reg;
        wr.en        = 1'b0;
        wr.addr      = count_reg[ADDR_W-1:0];
        wr.data      = rec_reg;

        if (begin_load)
        begin
            count_next   = '0;
            loading_next = 1'b1;
            skip_next    = 1'b1;
            phase_next   = PH_OUT;
            acc_next     = '0;
            rec_next     = '0;
        end
        else if (byte_valid && loading_reg)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_OUT:
                    begin
                        if (ch == CH_CR)
                        begin
                            if (count_reg < limit)
                            begin
                                wr.en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            rec_next = '0;
                            if (count_next >= limit)
                            begin
                                loading_next = 1'b0;
                            end
                        end
                        else if (ch == CH_OPEN)
                        begin
                            acc_next = '0;
                            if (month_mode)
                            begin
                                rec_next.day = '0;
                                phase_next   = PH_MONTH;
                            end
                            else
                            begin
                                phase_next = PH_DAY;
                            end
                        end
                    end
                    default:
                    begin
                        if (ch == end_ch)
                        begin
                            case (phase_reg)
                                PH_DAY:
                                begin
                                    rec_next.day = acc_reg;
                                    phase_next   = PH_MONTH;
                                end
                                PH_MONTH:
                                begin
                                    rec_next.month = acc_reg;
                                    phase_next     = PH_YEAR;
                                end
                                default:
                                begin
                                    rec_next.year = acc_reg;
                                    phase_next    = PH_OUT;
                                end
                            endcase
                            acc_next = '0;
                        end
                        else if (ch inside {[CH_ZERO:CH_NINE]})
                        begin
                            acc_next = acc_mac;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            loading_reg <= 1'b0;
            skip_reg    <= 1'b0;
            phase_reg   <= PH_OUT;
            acc_reg     <= '0;
            rec_reg     <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            loading_reg <= loading_next;
            skip_reg    <= skip_next;
            phase_reg   <= phase_next;
            acc_reg     <= acc_next;
            rec_reg     <= rec_next;
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import mdlpm_pkg::*;

    // Operation code 3 has no meaning in the block; it must be dropped quietly.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] data;
    } beat_t;

    // Tracks the parser and the date table, and holds the match positions still owed.
    class date_match_scoreboard;
        bit [7:0]    tbl_day [TABLE_DEPTH];
        bit [7:0]    tbl_month [TABLE_DEPTH];
        bit [7:0]    tbl_year [TABLE_DEPTH];
        int unsigned stored_count;
        bit          loading;
        bit          skip_next;
        bit          month_mode;
        phase_t      phase = PH_OUT;
        bit [7:0]    acc;
        bit [7:0]    rec_day;
        bit [7:0]    rec_month;
        bit [7:0]    rec_year;
        logic [7:0]  expected_positions[$];
        int unsigned beats;
        int unsigned loads;
        int unsigned records;
        int unsigned lookups;
        int unsigned mismatches;

        function void accept_beat(logic [1:0] op, logic [31:0] data);
            bit [6:0]    ch;
            int unsigned lim;
            int unsigned i;
            bit [7:0]    pos;
            beats++;
            lim = month_mode ? MONTH_LIMIT : DAY_LIMIT;
            ch = data[6:0];
            case (op)
                OP_BEGIN:
                begin
                    stored_count = 0;
                    loading = 1;
                    skip_next = 1;
                    phase = PH_OUT;
                    acc = 0;
                    rec_day = 0;
                    rec_month = 0;
                    rec_year = 0;
                    loads++;
                end
                OP_BYTE:
                begin
                    if (loading && skip_next)
                        skip_next = 0;
                    else if (loading && phase == PH_OUT)
                    begin
                        // Outside a record only CR and '(' do anything.
                        if (ch == CH_CR)
                        begin
                            if (stored_count < lim)
                            begin
                                tbl_day[stored_count] = rec_day;
                                tbl_month[stored_count] = rec_month;
                                tbl_year[stored_count] = rec_year;
                                stored_count++;
                                records++;
                            end
                            rec_day = 0;
                            rec_month = 0;
                            rec_year = 0;
                            if (stored_count >= lim)
                                loading = 0;
                        end
                        else if (ch == CH_OPEN)
                        begin
                            acc = 0;
                            if (month_mode)
                            begin
                                rec_day = 0;
                                phase = PH_MONTH;
                            end
                            else
                                phase = PH_DAY;
                        end
                    end
                    else if (loading)
                    begin
                        // Inside a record: a field ends on '.', the year on ')'.
                        if (ch == ((phase == PH_YEAR) ? CH_CLOSE : CH_DOT))
                        begin
                            case (phase)
                                PH_DAY:
                                begin
                                    rec_day = acc;
                                    phase = PH_MONTH;
                                end
                                PH_MONTH:
                                begin
                                    rec_month = acc;
                                    phase = PH_YEAR;
                                end
                                default:
                                begin
                                    rec_year = acc;
                                    phase = PH_OUT;
                                end
                            endcase
                            acc = 0;
                        end
                        else if (ch >= CH_ZERO && ch <= CH_NINE)
                            acc = 8'(acc * 10 + ch - CH_ZERO);
                    end
                end
                OP_LOOKUP:
                begin
                    // Walk down from the top so the lowest matching slot wins.
                    pos = 0;
                    for (i = stored_count; i > 0; i--)
                    begin
                        if (tbl_month[i-1] == data[23:16] && tbl_year[i-1] == data[31:24]
                            && (month_mode || tbl_day[i-1] == data[15:8]))
                            pos = 8'(i);
                    end
                    expected_positions.push_back(pos);
                    lookups++;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_match(logic [7:0] got);
            logic [7:0] want;
            if (expected_positions.size() == 0)
            begin
                $error("match_position: no lookup pending, expected none, actual %0d", got);
                mismatches++;
                return;
            end
            want = expected_positions.pop_front();
            if (got !== want)
            begin
                $error("match_position mismatch: expected %0d, actual %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // reply_byte, query_day, query_month, query_year
    logic [1:0]  s_axis_tuser;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // match_position

    date_match_scoreboard sb = new();
    beat_t                meter_beats[$];
    bit [23:0]            known_dates[$];   // {day, month, year} as the load should store them

    meter_date_list_parse_and_match DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Stimulus building.
    function automatic void push_beat(logic [1:0] op, logic [31:0] data);
        beat_t b;
        b.op = op;
        b.data = data;
        meter_beats.push_back(b);
    endfunction

    function automatic void push_char(bit [7:0] c);
        push_beat(OP_BYTE, {24'($urandom), c});
    endfunction

    // The top bit is masked off by the parser, so set it now and then.
    function automatic bit high_bit(bit noisy);
        return noisy && ($urandom_range(0, 7) == 0);
    endfunction

    function automatic void push_number(int unsigned v, bit noisy);
        string s;
        byte   c;
        int    k;
        s = $sformatf("%0d", v);
        if (noisy && $urandom_range(0, 5) == 0)
            s = {"0", s};
        for (k = 0; k < s.len(); k++)
        begin
            // Characters the parser must skip, CR inside a record among them.
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: push_char({high_bit(1), CH_CR});
                    1: push_char(" ");
                    2: push_char(8'("A" + $urandom_range(0, 25)));
                    default: push_char({high_bit(1), CH_OPEN});
                endcase
            end
            c = s[k];
            push_char({high_bit(noisy), c[6:0]});
        end
    endfunction

    function automatic int unsigned random_field(int unsigned lo, int unsigned hi);
        case ($urandom_range(0, 19))
            0, 1: return $urandom_range(0, 255);
            2: return $urandom_range(256, 999);
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    // Sends one parenthesized record (no CR) and returns what it should parse to.
    function automatic bit [23:0] push_random_record(bit mm);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        d = mm ? 0 : random_field(1, 31);
        m = random_field(1, 12);
        y = random_field(0, 99);
        push_char({high_bit(1), CH_OPEN});
        if (!mm)
        begin
            push_number(d, 1);
            push_char({high_bit(1), CH_DOT});
        end
        push_number(m, 1);
        push_char({high_bit(1), CH_DOT});
        push_number(y, 1);
        push_char({high_bit(1), CH_CLOSE});
        return {8'(d), 8'(m), 8'(y)};
    endfunction

    function automatic void push_lookup(bit mm);
        bit [23:0] dt;
        bit [7:0]  qd;
        if (known_dates.size() == 0 || $urandom_range(0, 9) >= 7)
            dt = 24'($urandom);
        else
        begin
            dt = known_dates[$urandom_range(0, known_dates.size() - 1)];
            if ($urandom_range(0, 5) == 0)
                dt ^= 24'(1) << $urandom_range(0, 23);
        end
        if ($urandom_range(0, 15) == 0)
            dt = {24{dt[0]}};
        qd = mm ? 8'($urandom) : dt[23:16];
        push_beat(OP_LOOKUP, {dt[7:0], dt[15:8], qd, 8'($urandom)});
    endfunction

    // One load: begin, the dropped byte, n entries, lookups along the way and after.
    // With real_odds nonzero most entries are bare CRs and one in real_odds is a record.
    function automatic void gen_load(bit mm, int n, int real_odds);
        int        r;
        int        kind;
        bit [23:0] dt;
        push_beat(OP_BEGIN, $urandom);
        push_char(8'($urandom));
        known_dates.delete();
        for (r = 0; r < n; r++)
        begin
            if (real_odds != 0)
                kind = ($urandom_range(1, real_odds) == 1) ? 4 : 0;
            else
                kind = $urandom_range(0, 15);
            if (kind == 1)
                push_beat(OP_BYTE, $urandom);
            else if (kind == 2)
                push_beat(OP_UNUSED, $urandom);
            else
            begin
                dt = 0;
                // A second record before the CR replaces the first.
                if (kind == 3)
                    dt = push_random_record(mm);
                if (kind != 0)
                    dt = push_random_record(mm);
                push_char({high_bit(1), CH_CR});
                known_dates.push_back(dt);
            end
            if ($urandom_range(0, 3) == 0)
                push_lookup(mm);
        end
        repeat ($urandom_range(2, 5))
            push_lookup(mm);
    endfunction

    function automatic void gen_phase(bit mm, int target);
        while (meter_beats.size() < target)
            gen_load(mm, $urandom_range(0, 8), 0);
    endfunction

    // Sender: bursts of random length with random gaps, one beat per handshake.
    task automatic send_beats();
        beat_t cur;
        bit    busy;
        int    burst_left;
        int    gap_left;
        busy = 0;
        gap_left = 0;
        burst_left = $urandom_range(1, 24);
        while (meter_beats.size() != 0 || busy)
        begin
            @(posedge clk);
            if (busy && s_axis_tvalid && s_axis_tready)
            begin
                sb.accept_beat(cur.op, cur.data);
                busy = 0;
            end
            if (!busy && gap_left > 0)
                gap_left--;
            else if (!busy && meter_beats.size() != 0)
            begin
                cur = meter_beats.pop_front();
                busy = 1;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                            : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            s_axis_tvalid <= busy;
            s_axis_tuser  <= cur.op;
            s_axis_tdata  <= cur.data;
        end
    endtask

    // Waits for every owed result, then past the longest lookup scan.
    task automatic settle();
        while (sb.expected_positions.size() != 0)
            @(posedge clk);
        repeat (140) @(posedge clk);
    endtask

    task automatic write_mode(bit mm);
        cfg_wr_en   <= 1;
        cfg_wr_data <= mm;
        @(posedge clk);
        cfg_wr_en   <= 0;
        sb.month_mode = mm;
    endtask

    // Receiver: randomly chosen stall styles that change from span to span, plus one long hold-off.
    initial
    begin
        int style;
        int span;
        int hold;
        int taken;
        bit held;
        style = 0;
        span = 0;
        hold = 0;
        taken = 0;
        held = 0;
        m_axis_tready <= 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (!held && taken == 40)
            begin
                hold = 600;
                held = 1;
            end
            if (span == 0)
            begin
                style = $urandom_range(0, 2);
                span = $urandom_range(16, 96);
            end
            span--;
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 0;
            end
            else if (style == 0)
                m_axis_tready <= 1;
            else if (style == 1)
                m_axis_tready <= 1'($urandom_range(0, 1));
            else
                m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_match(m_axis_tdata);
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Main sequence.
    initial
    begin
        rst_n         <= 0;
        cfg_wr_en     <= 0;
        cfg_wr_data   <= 0;
        s_axis_tvalid <= 0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_BEGIN;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        write_mode(0);

        // Directed: bytes before any begin, the dropped byte, field extremes with
        // digit overflow, masked characters, an empty record and unused operation 3.
        push_char({1'b0, CH_OPEN});
        push_beat(OP_LOOKUP, '1);
        push_beat(OP_BEGIN, '0);
        push_char({1'b1, CH_OPEN});
        push_char({1'b0, CH_OPEN});
        push_number(255, 0);
        push_char({1'b0, CH_DOT});
        push_char(8'h80 | "1");
        push_char("x");
        push_char({1'b0, CH_DOT});
        push_number(999, 0);
        push_char({1'b0, CH_CLOSE});
        push_char({1'b1, CH_CR});
        push_char({1'b0, CH_CR});
        push_beat(OP_LOOKUP, {8'd231, 8'd1, 8'd255, 8'h00});
        push_beat(OP_LOOKUP, '0);
        push_beat(OP_LOOKUP, '1);
        push_beat(OP_UNUSED, '1);
        send_beats();
        settle();

        // Day mode, ending halfway through a record.
        gen_phase(0, 250);
        push_char({1'b0, CH_OPEN});
        push_number(17, 0);
        push_char({1'b0, CH_DOT});
        send_beats();
        settle();

        // Month mode finishes that record, then fills the month table past its limit.
        write_mode(1);
        push_number(5, 0);
        push_char({1'b0, CH_DOT});
        push_number(24, 0);
        push_char({1'b0, CH_CLOSE});
        push_char({1'b0, CH_CR});
        known_dates.push_back({8'd17, 8'd5, 8'd24});
        push_lookup(1);
        push_lookup(1);
        gen_load(1, MONTH_LIMIT + 3, 4);
        gen_phase(1, 260);
        send_beats();
        settle();

        // Day mode with the whole table filled, so a lookup that finds no match scans every slot.
        write_mode(0);
        gen_load(0, DAY_LIMIT + 3, 12);
        send_beats();
        settle();

        write_mode(1);
        gen_phase(1, 60);
        send_beats();
        settle();

        write_mode(0);
        gen_phase(0, 60);
        send_beats();
        settle();

        $display("Sent %0d beats in %0d loads: %0d records stored, %0d lookups checked.",
                 sb.beats, sb.loads, sb.records, sb.lookups);
        $display("Both date modes, full day and month tables and a long output stall ran.");
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mdlpm_pkg.sv
hw/rtl/mdlpm_ram.sv
hw/rtl/mdlpm_parser.sv
hw/rtl/meter_date_list_parse_and_match.sv
test/tb.sv
